>>> src/mcma_pkg.sv
// Package for the multichannel moving-average filter.
// Holds sizes, field widths and the reciprocal used for the window mean.
// No dependencies.
package mcma_pkg;

  localparam int CHANNELS = 14;
  localparam int WINDOW   = 8;

  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 12;
  localparam int DATA_W   = ((SAMPLE_W + 7) / 8) * 8;

  localparam int LOG_W    = $clog2(WINDOW);
  localparam int SLOT_W   = (WINDOW > 1) ? LOG_W : 1;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRIES  = CHANNELS * WINDOW;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SUM_W    = SAMPLE_W + LOG_W;

  localparam int RECIP_SHIFT = SUM_W + LOG_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CH_W-1:0]     ch_idx_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CHAN_W-1:0]   chan_t;

endpackage

>>> src/mcma_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mcma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/multichannel_moving_average.sv
// Top level of the multichannel moving-average filter.
// Uses mcma_pkg and two mcma_ram instances (sample window store, channel sums).
//
// channel  dir  tdata (low bit up)     tuser (low bit up)
// s        in   sample[11:0], zeros    channel[3:0]
// m        out  average[11:0], zeros   out_channel[3:0]
//
// One word per cycle, unless m_tready holds the output register and stalls.
// Stage 0 reads the window entry and channel sum, stage 1 updates and
// writes them back; a write to the entry read in the same cycle is forwarded.
// Reset clears valid bits for every entry, so the stores read as zero at once.
// The output register lets a new word enter while a result waits.
module multichannel_moving_average (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mcma_pkg::DATA_W-1:0]    s_tdata,   // sample
  input  logic [mcma_pkg::CHAN_W-1:0]    s_tuser,   // channel
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mcma_pkg::DATA_W-1:0]    m_tdata,   // average
  output logic [mcma_pkg::CHAN_W-1:0]    m_tuser    // out_channel
);
  import mcma_pkg::*;

  logic         accept;
  logic         in_range;
  chan_t        in_chan;
  sample_t      in_sample;
  ch_idx_t      rd_ch;
  idx_t         rd_idx;

  slot_t        slot;
  slot_t        slot_next;

  logic [ENTRIES-1:0]  win_vld;
  logic [CHANNELS-1:0] sum_vld;

  logic         s1_valid;
  logic         s1_in_range;
  chan_t        s1_chan;
  sample_t      s1_sample;
  idx_t         s1_idx;
  ch_idx_t      s1_ch;
  logic         s1_win_vld;
  logic         s1_sum_vld;
  logic         s1_fwd_win;
  logic         s1_fwd_sum;
  sample_t      s1_fwd_win_data;
  sum_t         s1_fwd_sum_data;
  logic         s1_adv;
  logic         wr_en;

  sample_t      win_rd;
  sum_t         sum_rd;
  sample_t      old_sample;
  sum_t         old_sum;
  sum_t         new_sum;
  logic [PROD_W-1:0] prod;
  sample_t      avg;

  assign in_chan   = s_tuser;
  assign in_sample = s_tdata[SAMPLE_W-1:0];
  assign in_range  = 32'(in_chan) < CHANNELS;
  assign rd_ch     = CH_W'(in_chan);
  assign rd_idx    = IDX_W'(rd_ch) * IDX_W'(WINDOW) + IDX_W'(slot);

  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = s1_valid && s1_adv && s1_in_range;

  always_comb begin
    slot_next = slot;
    if (accept && in_range && (32'(in_chan) == CHANNELS - 1)) begin
      slot_next = (32'(slot) == WINDOW - 1) ? '0 : slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

  mcma_ram #(.WIDTH(SAMPLE_W), .DEPTH(ENTRIES)) u_win_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (s1_sample),
    .rd_en   (accept),
    .rd_addr (rd_idx),
    .rd_data (win_rd)
  );

  mcma_ram #(.WIDTH(SUM_W), .DEPTH(CHANNELS)) u_sum_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_ch),
    .wr_data (new_sum),
    .rd_en   (accept),
    .rd_addr (rd_ch),
    .rd_data (sum_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
      sum_vld <= '0;
    end else if (wr_en) begin
      win_vld[s1_idx] <= 1'b1;
      sum_vld[s1_ch]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range     <= in_range;
      s1_chan         <= in_chan;
      s1_sample       <= in_sample;
      s1_idx          <= rd_idx;
      s1_ch           <= rd_ch;
      s1_win_vld      <= in_range && win_vld[rd_idx];
      s1_sum_vld      <= in_range && sum_vld[rd_ch];
      s1_fwd_win      <= wr_en && (s1_idx == rd_idx);
      s1_fwd_sum      <= wr_en && (s1_ch == rd_ch);
      s1_fwd_win_data <= s1_sample;
      s1_fwd_sum_data <= new_sum;
    end
  end

  always_comb begin
    if (s1_fwd_win) begin
      old_sample = s1_fwd_win_data;
    end else if (s1_win_vld) begin
      old_sample = win_rd;
    end else begin
      old_sample = '0;
    end
    if (s1_fwd_sum) begin
      old_sum = s1_fwd_sum_data;
    end else if (s1_sum_vld) begin
      old_sum = sum_rd;
    end else begin
      old_sum = '0;
    end
    new_sum = old_sum - SUM_W'(old_sample) + SUM_W'(s1_sample);
    prod    = PROD_W'(new_sum) * PROD_W'(RECIP);
    avg     = s1_in_range ? prod[RECIP_SHIFT +: SAMPLE_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      m_tuser <= s1_chan;
      m_tdata <= DATA_W'(avg);
    end
  end

endmodule
